// ===== design/otafr_pkg.sv =====
package otafr_pkg;

    localparam int CAPACITY = 16;
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    typedef enum logic [1:0] {
        CMD_APPEND = 2'd0,
        CMD_REMOVE = 2'd1,
        CMD_FIND   = 2'd2,
        CMD_NONE   = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_DONE      = 2'd0,
        ST_FULL      = 2'd1,
        ST_NOT_FOUND = 2'd2
    } t_status;

    typedef struct packed {
        logic [15:0]        id;
        logic [31:0]        price;
        logic signed [31:0] stock;
    } t_entry;

    typedef struct packed {
        logic [1:0]         cmd;
        logic [15:0]        key_id;
        logic [31:0]        entry_price_bits;
        logic signed [31:0] entry_stock;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  status;
        logic [3:0]  found_index;
        logic [15:0] assigned_id;
        logic [4:0]  entries_held;
    } t_out_item;

    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] waddr;
        t_entry           wdata;
        logic [IDX_W-1:0] raddr;
    } t_mem_req;

endpackage

// ===== design/otafr_if.sv =====
interface otafr_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         cmd;
    logic [15:0]        key_id;
    logic [31:0]        entry_price_bits;
    logic signed [31:0] entry_stock;

    modport source (output valid, output cmd, output key_id, output entry_price_bits,
                    output entry_stock, input ready);
    modport sink   (input valid, input cmd, input key_id, input entry_price_bits,
                    input entry_stock, output ready);
endinterface

interface otafr_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [3:0]  found_index;
    logic [15:0] assigned_id;
    logic [4:0]  entries_held;

    modport source (output valid, output status, output found_index, output assigned_id,
                    output entries_held, input ready);
    modport sink   (input valid, input status, input found_index, input assigned_id,
                    input entries_held, output ready);
endinterface

// ===== design/otafr_table.sv =====
module otafr_table (
    input  logic                i_clk,
    input  otafr_pkg::t_mem_req i_req,
    output otafr_pkg::t_entry   o_rd_entry
);

    otafr_pkg::t_entry r_mem [otafr_pkg::CAPACITY];
    otafr_pkg::t_entry r_rd_entry;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        r_rd_entry <= r_mem[i_req.raddr];
    end

    assign o_rd_entry = r_rd_entry;

endmodule

// ===== design/otafr_ctrl.sv =====
module otafr_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  otafr_pkg::t_in_item  i_in_item,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output otafr_pkg::t_out_item o_out_item,
    output otafr_pkg::t_mem_req  o_mem_req,
    input  otafr_pkg::t_entry    i_rd_entry
);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_APPEND = 5'b00010,
        S_SCAN   = 5'b00100,
        S_SHIFT  = 5'b01000,
        S_REPLY  = 5'b10000
    } t_state;

    localparam int CNT_W = otafr_pkg::CNT_W;
    localparam int IDX_W = otafr_pkg::IDX_W;

    t_state                r_state, n_state;
    logic [CNT_W-1:0]      r_count, n_count;
    logic [CNT_W-1:0]      r_idx, n_idx;
    logic [CNT_W-1:0]      r_found, n_found;
    logic [1:0]            r_status, n_status;
    logic [15:0]           r_assigned, n_assigned;
    otafr_pkg::t_in_item   r_item, n_item;
    logic [CNT_W-1:0]      idx_next;
    logic                  id_match;
    logic                  last_idx;
    logic [15:0]           next_id;

    // shared compare / increment datapath
    assign idx_next = CNT_W'(r_idx + 1'b1);
    assign last_idx = (idx_next >= r_count);
    assign id_match = (i_rd_entry.id == r_item.key_id);
    assign next_id  = i_rd_entry.id + 16'd1;

    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_idx      = r_idx;
        n_found    = r_found;
        n_status   = r_status;
        n_assigned = r_assigned;
        n_item     = r_item;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        o_mem_req.we    = 1'b0;
        o_mem_req.waddr = IDX_W'(r_idx);
        o_mem_req.wdata = i_rd_entry;
        o_mem_req.raddr = IDX_W'(idx_next);

        unique case (r_state)
            S_IDLE: begin
                o_in_ready      = 1'b1;
                o_mem_req.raddr = '0;
                if (i_in_valid) begin
                    n_item     = i_in_item;
                    n_idx      = '0;
                    n_found    = '0;
                    n_status   = otafr_pkg::ST_DONE;
                    n_assigned = '0;
                    unique case (i_in_item.cmd)
                        otafr_pkg::CMD_APPEND: begin
                            if (r_count >= CNT_W'(otafr_pkg::CAPACITY)) begin
                                n_status = otafr_pkg::ST_FULL;
                                n_state  = S_REPLY;
                            end else if (r_count == '0) begin
                                o_mem_req.we          = 1'b1;
                                o_mem_req.waddr       = '0;
                                o_mem_req.wdata.id    = 16'd1;
                                o_mem_req.wdata.price = i_in_item.entry_price_bits;
                                o_mem_req.wdata.stock = i_in_item.entry_stock;
                                n_count    = CNT_W'(1);
                                n_assigned = 16'd1;
                                n_state    = S_REPLY;
                            end else begin
                                o_mem_req.raddr = IDX_W'(r_count - 1'b1);
                                n_state         = S_APPEND;
                            end
                        end
                        otafr_pkg::CMD_REMOVE, otafr_pkg::CMD_FIND: begin
                            if (r_count == '0) begin
                                n_status = otafr_pkg::ST_NOT_FOUND;
                                n_state  = S_REPLY;
                            end else begin
                                n_state = S_SCAN;
                            end
                        end
                        default: begin
                            n_state = S_REPLY;
                        end
                    endcase
                end
            end
            S_APPEND: begin
                o_mem_req.we          = 1'b1;
                o_mem_req.waddr       = IDX_W'(r_count);
                o_mem_req.wdata.id    = next_id;
                o_mem_req.wdata.price = r_item.entry_price_bits;
                o_mem_req.wdata.stock = r_item.entry_stock;
                n_count    = CNT_W'(r_count + 1'b1);
                n_assigned = next_id;
                n_state    = S_REPLY;
            end
            S_SCAN: begin
                // read data holds entry r_idx; read of r_idx+1 is issued
                if (id_match) begin
                    n_found = r_idx;
                    n_state = (r_item.cmd == otafr_pkg::CMD_REMOVE) ? S_SHIFT : S_REPLY;
                end else if (last_idx) begin
                    n_status = otafr_pkg::ST_NOT_FOUND;
                    n_state  = S_REPLY;
                end else begin
                    n_idx = idx_next;
                end
            end
            S_SHIFT: begin
                // read data holds entry r_idx+1; move it down to r_idx
                o_mem_req.raddr = IDX_W'(r_idx + 2'd2);
                if (last_idx) begin
                    n_count = CNT_W'(r_count - 1'b1);
                    n_state = S_REPLY;
                end else begin
                    o_mem_req.we = 1'b1;
                    n_idx        = idx_next;
                end
            end
            S_REPLY: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_idx   <= n_idx;
        end
        r_found    <= n_found;
        r_status   <= n_status;
        r_assigned <= n_assigned;
        r_item     <= n_item;
    end

    assign o_out_item.status       = r_status;
    assign o_out_item.found_index  = 4'(r_found);
    assign o_out_item.assigned_id  = r_assigned;
    assign o_out_item.entries_held = 5'(r_count);

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(otafr_pkg::CAPACITY))
        else $error("entry count above capacity");

    a_walk_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN || r_state == S_SHIFT) |-> (r_idx < r_count))
        else $error("walk index beyond held entries");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("accepted a second transaction while busy");

    a_remove_shrinks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SHIFT && last_idx) |=> (r_count == $past(r_count) - 1'b1))
        else $error("remove did not decrement count");

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_in_ready && o_out_valid))
        else $error("ready and result valid together");

endmodule

// ===== design/ordered_table_append_find_remove_unit.sv =====
// Ordered record table: append, find by identifier, remove by identifier.
//
// Channels: i_req (sink) carries one command transaction (cmd, key_id,
// entry_price_bits, entry_stock); o_rsp (source) returns exactly one result
// transaction per command (status, found_index, assigned_id, entries_held).
// Both use valid/ready; a transaction moves when both are high on a clock edge.
//
// The block handles one command at a time; i_req.ready is high only while idle.
// Steps from accept to o_rsp.valid:
//   append        direct if empty or full, else reads the last identifier
//   find          direct if empty, else scan from entry 0 to a match or end
//   remove        as find, then shifts later entries down and retires
// The table's single read port walks one entry per cycle during the scan and
// the close-up shift.
//
// Reset (i_rst_n, synchronous, active low) empties the table; no clearing pass
// is needed since data from positions at or above the count is never used.
// When the receiver stalls, the result is held in registers with o_rsp.valid
// high until it is taken; no new command is accepted meanwhile.
module ordered_table_append_find_remove_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    otafr_in_if.sink    i_req,
    otafr_out_if.source o_rsp
);

    otafr_pkg::t_in_item  in_item;
    otafr_pkg::t_out_item out_item;
    otafr_pkg::t_mem_req  mem_req;
    otafr_pkg::t_entry    rd_entry;

    // command payload gathered into one struct for the sequencer
    assign in_item.cmd              = i_req.cmd;
    assign in_item.key_id           = i_req.key_id;
    assign in_item.entry_price_bits = i_req.entry_price_bits;
    assign in_item.entry_stock      = i_req.entry_stock;

    // sequencer: scan/compare/shift state machine and result registers
    otafr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .o_in_ready  (i_req.ready),
        .i_in_item   (in_item),
        .o_out_valid (o_rsp.valid),
        .i_out_ready (o_rsp.ready),
        .o_out_item  (out_item),
        .o_mem_req   (mem_req),
        .i_rd_entry  (rd_entry)
    );

    // record storage: one write port, one registered read port
    otafr_table u_table (
        .i_clk      (i_clk),
        .i_req      (mem_req),
        .o_rd_entry (rd_entry)
    );

    assign o_rsp.status       = out_item.status;
    assign o_rsp.found_index  = out_item.found_index;
    assign o_rsp.assigned_id  = out_item.assigned_id;
    assign o_rsp.entries_held = out_item.entries_held;

endmodule

// ===== bench/otafr_table_checker.sv =====
`timescale 1ns / 1ps
// Scoreboard for the ordered record table: mirrors the table contents, predicts one
// reply per accepted command and compares replies in order.
module otafr_table_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    otafr_in_if         i_req,
    otafr_out_if        i_rsp,
    output int          o_fail_count,
    output int          o_outstanding,
    output int          o_checked,
    output int          o_full_seen,
    output int          o_miss_seen,
    output int          o_dup_seen,
    output logic [15:0] o_newest_id
);

    otafr_pkg::t_entry    table_rows [otafr_pkg::CAPACITY];
    int                   held_count    = 0;
    otafr_pkg::t_out_item expected_replies [$];

    int fail_count    = 0;
    int checked_count = 0;
    int full_count    = 0;
    int miss_count    = 0;
    int dup_count     = 0;

    // Applies one command to the mirrored table and returns the reply it must produce.
    function automatic otafr_pkg::t_out_item apply_command(input logic [1:0] op,
                                                           input logic [15:0] key,
                                                           input logic [31:0] price,
                                                           input logic signed [31:0] stock);
        otafr_pkg::t_out_item reply;
        logic [15:0]          fresh_id;
        int                   hit;
        logic                 repeated;
        reply    = '0;
        hit      = -1;
        repeated = 1'b0;
        case (otafr_pkg::t_cmd'(op))
            otafr_pkg::CMD_APPEND: begin
                if (held_count >= otafr_pkg::CAPACITY) begin
                    reply.status = otafr_pkg::ST_FULL;
                    full_count++;
                end else begin
                    // next id follows the last entry, wraps at 16 bits
                    if (held_count == 0)
                        fresh_id = 16'd1;
                    else
                        fresh_id = table_rows[held_count - 1].id + 16'd1;
                    table_rows[held_count] = '{id: fresh_id, price: price, stock: stock};
                    held_count++;
                    reply.assigned_id = fresh_id;
                end
            end
            otafr_pkg::CMD_REMOVE, otafr_pkg::CMD_FIND: begin
                // scan downward so the lowest match wins; a second match is a duplicate
                for (int pos = held_count - 1; pos >= 0; pos--) begin
                    if (table_rows[pos].id == key) begin
                        repeated = repeated | (hit >= 0);
                        hit      = pos;
                    end
                end
                if (hit < 0) begin
                    reply.status = otafr_pkg::ST_NOT_FOUND;
                    miss_count++;
                end else begin
                    reply.found_index = hit[3:0];
                    dup_count += repeated;
                    if (otafr_pkg::t_cmd'(op) == otafr_pkg::CMD_REMOVE) begin
                        for (int pos = hit; pos < held_count - 1; pos++)
                            table_rows[pos] = table_rows[pos + 1];
                        held_count--;
                    end
                end
            end
            otafr_pkg::CMD_NONE: ;
        endcase
        reply.entries_held = held_count[4:0];
        return reply;
    endfunction

    function automatic void check_field(input string label, input logic [15:0] want,
                                        input logic [15:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, label, want, got);
            fail_count++;
        end
    endfunction

    always @(posedge i_clk) begin
        otafr_pkg::t_out_item wanted;
        if (!i_rst_n) begin
            held_count = 0;
            expected_replies.delete();
        end else begin
            // reply first: a reply never belongs to a command taken on the same edge
            if (i_rsp.valid && i_rsp.ready) begin
                if (expected_replies.size() == 0) begin
                    $display("%0t: reply with nothing outstanding, expected none, %s",
                             $time, "got status/index/id/held");
                    $display("    %0d/%0d/%0d/%0d", i_rsp.status, i_rsp.found_index,
                             i_rsp.assigned_id, i_rsp.entries_held);
                    fail_count++;
                end else begin
                    wanted = expected_replies.pop_front();
                    check_field("status", 16'(wanted.status), 16'(i_rsp.status));
                    check_field("found_index", 16'(wanted.found_index), 16'(i_rsp.found_index));
                    check_field("assigned_id", wanted.assigned_id, i_rsp.assigned_id);
                    check_field("entries_held", 16'(wanted.entries_held),
                                16'(i_rsp.entries_held));
                    checked_count++;
                end
            end
            if (i_req.valid && i_req.ready)
                expected_replies.push_back(apply_command(i_req.cmd, i_req.key_id,
                                                         i_req.entry_price_bits,
                                                         i_req.entry_stock));
        end
        o_fail_count  <= fail_count;
        o_outstanding <= expected_replies.size();
        o_checked     <= checked_count;
        o_full_seen   <= full_count;
        o_miss_seen   <= miss_count;
        o_dup_seen    <= dup_count;
        o_newest_id   <= (held_count == 0) ? 16'd0 : table_rows[held_count - 1].id;
    end

endmodule

// ===== bench/tb_ordered_table_append_find_remove_unit.sv =====
`timescale 1ns / 1ps
// Stimulus and verdict for the ordered record table. All prediction and comparison
// lives in the checker instance; this module only generates command transactions,
// throttles the reply channel and reports the result.
module tb_ordered_table_append_find_remove_unit;

    logic i_clk = 1'b0;
    logic i_rst_n;

    otafr_in_if  req_bus ();
    otafr_out_if rsp_bus ();

    int send_idle_pct;
    int recv_idle_pct;
    int hold_cycles_left = 0;
    int issued [4];

    int          fail_count;
    int          outstanding;
    int          checked;
    int          full_seen;
    int          miss_seen;
    int          dup_seen;
    logic [15:0] newest_id;

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    ordered_table_append_find_remove_unit i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_bus),
        .o_rsp   (rsp_bus)
    );

    otafr_table_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_req         (req_bus),
        .i_rsp         (rsp_bus),
        .o_fail_count  (fail_count),
        .o_outstanding (outstanding),
        .o_checked     (checked),
        .o_full_seen   (full_seen),
        .o_miss_seen   (miss_seen),
        .o_dup_seen    (dup_seen),
        .o_newest_id   (newest_id)
    );

    // Reply side: random back-pressure, or a long hold-off when one is requested.
    always @(posedge i_clk) begin
        if (hold_cycles_left > 0) begin
            rsp_bus.ready <= 1'b0;
            hold_cycles_left--;
        end else begin
            rsp_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Offers one command transaction, with random idle cycles ahead of it, and returns
    // on the edge where it is taken. valid stays high so back-to-back items don't glitch.
    task automatic push_command(input otafr_pkg::t_cmd op, input logic [15:0] key,
                                input logic [31:0] price, input logic signed [31:0] stock);
        while ($urandom_range(99) < send_idle_pct) begin
            req_bus.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_bus.valid            <= 1'b1;
        req_bus.cmd              <= op;
        req_bus.key_id           <= key;
        req_bus.entry_price_bits <= price;
        req_bus.entry_stock      <= stock;
        @(posedge i_clk);
        while (!req_bus.ready)
            @(posedge i_clk);
        issued[int'(op)]++;
    endtask

    // Sender goes quiet until every predicted reply has been returned.
    task automatic wait_for_replies();
        req_bus.valid <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0)
            @(posedge i_clk);
    endtask

    // Random command mix. The append share is redrawn every 60 items so the table
    // swings between empty and full; most keys sit just below the newest id so
    // finds and removes mostly hit.
    task automatic run_random_mix(input int count);
        int               append_pct;
        int               roll;
        otafr_pkg::t_cmd  op;
        logic [15:0]      key;
        append_pct = 50;
        for (int n = 0; n < count; n++) begin
            if (n % 60 == 0)
                append_pct = $urandom_range(90, 10);
            if (n == count / 4)
                hold_cycles_left = 400;
            roll = $urandom_range(99);
            if (roll < 3)
                op = otafr_pkg::CMD_NONE;
            else if (roll < 3 + append_pct)
                op = otafr_pkg::CMD_APPEND;
            else if ($urandom_range(1) == 0)
                op = otafr_pkg::CMD_REMOVE;
            else
                op = otafr_pkg::CMD_FIND;
            if ($urandom_range(3) == 0)
                key = 16'($urandom_range(16'hffff));
            else
                key = newest_id - 16'($urandom_range(24));
            push_command(op, key, $urandom, $urandom);
        end
    endtask

    initial begin
        i_rst_n                  = 1'b0;
        req_bus.valid            = 1'b0;
        req_bus.cmd              = otafr_pkg::CMD_NONE;
        req_bus.key_id           = '0;
        req_bus.entry_price_bits = '0;
        req_bus.entry_stock      = '0;
        rsp_bus.ready            = 1'b0;
        issued                   = '{default: 0};
        send_idle_pct            = 31;
        recv_idle_pct            = 62;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: empty-table misses, unused code, fill to capacity with extreme
        // payloads, full append, hits at both ends, remove last and remove first.
        push_command(otafr_pkg::CMD_FIND, 16'h0000, 32'h0, 32'sh0);
        push_command(otafr_pkg::CMD_REMOVE, 16'hffff, 32'h0, 32'sh0);
        push_command(otafr_pkg::CMD_NONE, 16'h0001, 32'hffffffff, -32'sd1);
        push_command(otafr_pkg::CMD_APPEND, 16'h0000, 32'h00000000, 32'sh80000000);
        push_command(otafr_pkg::CMD_APPEND, 16'hffff, 32'hffffffff, 32'sh7fffffff);
        for (int n = 0; n < otafr_pkg::CAPACITY - 2; n++)
            push_command(otafr_pkg::CMD_APPEND, 16'h0000, $urandom, $urandom);
        push_command(otafr_pkg::CMD_APPEND, 16'h0000, 32'h12345678, 32'sd5);
        push_command(otafr_pkg::CMD_FIND, 16'(otafr_pkg::CAPACITY), 32'h0, 32'sh0);
        push_command(otafr_pkg::CMD_FIND, 16'h0001, 32'h0, 32'sh0);
        push_command(otafr_pkg::CMD_NONE, 16'h0003, 32'h0, 32'sh0);
        push_command(otafr_pkg::CMD_REMOVE, 16'(otafr_pkg::CAPACITY), 32'h0, 32'sh0);
        push_command(otafr_pkg::CMD_REMOVE, 16'h0001, 32'h0, 32'sh0);
        push_command(otafr_pkg::CMD_FIND, 16'h0001, 32'h0, 32'sh0);

        run_random_mix(541);
        wait_for_replies();

        send_idle_pct = 62;
        recv_idle_pct = 31;
        run_random_mix(541);
        wait_for_replies();

        // no random idling on either side: commands back to back, apart from the long reply hold-off
        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_random_mix(541);
        wait_for_replies();
        repeat (2 * (otafr_pkg::CAPACITY + 2)) @(posedge i_clk);

        $display("Sent %0d appends, %0d removes, %0d finds, %0d unused codes,",
                 issued[otafr_pkg::CMD_APPEND], issued[otafr_pkg::CMD_REMOVE],
                 issued[otafr_pkg::CMD_FIND], issued[otafr_pkg::CMD_NONE]);
        $display("%0d replies compared: %0d full-table appends, %0d misses, %0d duplicate hits.",
                 checked, full_seen, miss_seen, dup_seen);
        if (fail_count == 0)
            $display("tb_ordered_table_append_find_remove_unit: clean");
        else
            $display("tb_ordered_table_append_find_remove_unit: errors");
        $finish;
    end

    // Watchdog, far beyond the slowest legal run.
    initial begin
        #4000000;
        $display("tb_ordered_table_append_find_remove_unit: errors");
        $finish;
    end

endmodule

// ===== files.f =====
design/otafr_pkg.sv
design/otafr_if.sv
design/otafr_table.sv
design/otafr_ctrl.sv
design/ordered_table_append_find_remove_unit.sv
bench/otafr_table_checker.sv
bench/tb_ordered_table_append_find_remove_unit.sv
